// ===== rtl/core/ssc_pkg.sv =====
// Shared types and constants for the stick square-to-circle mapper.
// Used by the controller, the datapath and the top level; depends on nothing.
package ssc_pkg;

  localparam int unsigned AXIS_W      = 8;
  localparam int unsigned RAD_W       = 16;
  localparam int unsigned ROOT_W      = 8;
  localparam int unsigned REM_W       = 11;
  localparam int unsigned MAG_W       = 15;
  localparam int unsigned ROOT_STEPS  = 8;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned NUM_LANES   = 2;

  localparam logic [16:0] RAD_BASE    = 17'd32768;
  localparam logic [7:0]  DIVISOR     = 8'd181;
  // floor(2^16 / 181): the quotient estimate is exact or one short.
  localparam logic [8:0]  RECIP       = 9'd362;
  localparam logic [7:0]  ROOT_MIN    = 8'd128;
  localparam logic [9:0]  CENTER      = 10'd128;
  localparam logic [9:0]  OUT_MAX     = 10'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT,
    S_MUL,
    S_RECIP,
    S_FIX,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic root_step;
    logic mul;
    logic recip;
    logic fix;
    logic publish;
  } dp_cmd_t;

endpackage

// ===== rtl/core/stick_square_to_circle.sv =====
// Top level of the stick square-to-circle mapper: ties the controller
// ssc_ctrl to the datapath ssc_dp. Depends on ssc_pkg.
//
// One stick sample (x, y, centered at 128) goes in per input beat, and one
// circle-mapped (x, y) comes out per output beat. Each sample passes through
// a square step, eight iterations of the per-lane digit-by-digit square root,
// then a multiply, a reciprocal divide by 181 and a correction step; no new
// sample is taken until the last result has moved into the output register.
// The result sits in that register, so the next sample is taken while it
// waits. The block holds no state between samples.
module stick_square_to_circle
  import ssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [AXIS_W-1:0] in_axis_x,
  input  logic [AXIS_W-1:0] in_axis_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AXIS_W-1:0] out_round_x,
  output logic [AXIS_W-1:0] out_round_y
);

  dp_cmd_t cmd;

  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ssc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .axis_x  (in_axis_x),
    .axis_y  (in_axis_y),
    .round_x (out_round_x),
    .round_y (out_round_y)
  );

endmodule

// ===== rtl/core/ssc_ctrl.sv =====
// Sequencing controller for the stick mapper: walks one sample through the
// square, root, multiply and divide steps. Depends on ssc_pkg.
module ssc_ctrl
  import ssc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        // The result moves into the output register once it is empty or draining.
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || !out_stall))
    else $error("result published over an untaken output beat");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SQUARE))
    else $error("accepted beat did not start the square step");

  a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQUARE) |=> (state_r == S_ROOT && cnt_r == '0))
    else $error("root iteration did not start from step zero");

endmodule

// ===== rtl/core/ssc_dp.sv =====
// Datapath for the stick mapper: two lanes, each with a radicand, a
// digit-by-digit square root, a multiply and a reciprocal divide by 181.
// Depends on ssc_pkg; driven by commands from ssc_ctrl.
module ssc_dp
  import ssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [AXIS_W-1:0] axis_x,
  input  logic [AXIS_W-1:0] axis_y,
  output logic [AXIS_W-1:0] round_x,
  output logic [AXIS_W-1:0] round_y
);

  // Lane 0 produces the horizontal result, lane 1 the vertical one.
  logic signed [AXIS_W-1:0] n_r    [NUM_LANES];
  logic [RAD_W-1:0]         rad_r  [NUM_LANES];
  logic [REM_W-1:0]         rem_r  [NUM_LANES];
  logic [ROOT_W-1:0]        root_r [NUM_LANES];
  logic [MAG_W-1:0]         mag_r  [NUM_LANES];
  logic                     neg_r  [NUM_LANES];
  logic [ROOT_W-1:0]        est_r  [NUM_LANES];
  logic [AXIS_W-1:0]        res_r  [NUM_LANES];
  logic [AXIS_W-1:0]        out_r  [NUM_LANES];

  logic [RAD_W-1:0]         rad_nxt  [NUM_LANES];
  logic [REM_W-1:0]         rem_nxt  [NUM_LANES];
  logic [ROOT_W-1:0]        root_nxt [NUM_LANES];
  logic [MAG_W-1:0]         mag_nxt  [NUM_LANES];
  logic                     neg_nxt  [NUM_LANES];
  logic [ROOT_W-1:0]        est_nxt  [NUM_LANES];
  logic [AXIS_W-1:0]        res_nxt  [NUM_LANES];
  logic [MAG_W-1:0]         rmd      [NUM_LANES];

  always_comb begin
    logic signed [15:0]  sq;
    logic [16:0]         diff;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic signed [16:0]  prod;
    logic [16:0]         prod_abs;
    logic [23:0]         scaled;
    logic [15:0]         back;
    logic [ROOT_W-1:0]   q;
    logic signed [9:0]   sq_off;
    logic signed [9:0]   r;
    for (int i = 0; i < NUM_LANES; i++) begin
      // The cross term of a lane comes from the other axis.
      sq       = 16'(n_r[NUM_LANES-1-i]) * 16'(n_r[NUM_LANES-1-i]);
      diff     = RAD_BASE - {1'b0, sq};
      rad_nxt[i] = diff[RAD_W-1:0];

      rem_sh   = {rem_r[i], rad_r[i][RAD_W-1 -: 2]};
      trial    = {3'b000, root_r[i], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[i]  = REM_W'(rem_sh - trial);
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = rem_sh[REM_W-1:0];
        root_nxt[i] = {root_r[i][ROOT_W-2:0], 1'b0};
      end

      prod       = 17'(n_r[i]) * 17'($signed({1'b0, root_r[i]}));
      prod_abs   = prod[16] ? 17'(-prod) : prod;
      mag_nxt[i] = prod_abs[MAG_W-1:0];
      neg_nxt[i] = prod[16];

      scaled     = {9'd0, mag_r[i]} * {15'd0, RECIP};
      est_nxt[i] = scaled[23:16];

      // The estimate is at most one short of the true quotient.
      back       = {8'd0, est_r[i]} * {8'd0, DIVISOR};
      rmd[i]     = MAG_W'({1'b0, mag_r[i]} - back);
      q          = (rmd[i] >= MAG_W'(DIVISOR)) ? est_r[i] + 1'b1 : est_r[i];
      sq_off     = neg_r[i] ? -$signed({2'b00, q}) : $signed({2'b00, q});
      r          = sq_off + $signed(CENTER);
      if (r < 0) begin
        res_nxt[i] = '0;
      end else if (r > $signed(OUT_MAX)) begin
        res_nxt[i] = OUT_MAX[AXIS_W-1:0];
      end else begin
        res_nxt[i] = r[AXIS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r[0] <= $signed({~axis_x[AXIS_W-1], axis_x[AXIS_W-2:0]});
      n_r[1] <= $signed({~axis_y[AXIS_W-1], axis_y[AXIS_W-2:0]});
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (cmd.square) begin
        rad_r[i]  <= rad_nxt[i];
        rem_r[i]  <= '0;
        root_r[i] <= '0;
      end
      if (cmd.root_step) begin
        rad_r[i]  <= {rad_r[i][RAD_W-3:0], 2'b00};
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
      end
      if (cmd.mul) begin
        mag_r[i] <= mag_nxt[i];
        neg_r[i] <= neg_nxt[i];
      end
      if (cmd.recip) begin
        est_r[i] <= est_nxt[i];
      end
      if (cmd.fix) begin
        res_r[i] <= res_nxt[i];
      end
      if (cmd.publish) begin
        out_r[i] <= res_r[i];
      end
    end
  end

  assign round_x = out_r[0];
  assign round_y = out_r[1];

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (root_r[0] >= ROOT_MIN && root_r[0] <= DIVISOR &&
                 root_r[1] >= ROOT_MIN && root_r[1] <= DIVISOR))
    else $error("square root left its expected range");

  a_recip_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fix |-> (rmd[0] < MAG_W'(2 * 181) && rmd[1] < MAG_W'(2 * 181)))
    else $error("quotient estimate off by more than one");

endmodule
